// File: rtl/efra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drop-oldest FIFO with running mean: shared definitions
// Request and status codes, field widths and the default queue depth.
// ----------------------------------------------------------------------------
package efra_pkg;

    localparam int QueueDepthDefault = 5;

    localparam int TagW    = 16;
    localparam int HeightW = 8;
    localparam int StatusW = 2;

    // Request kinds carried in the input tuser.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Result status carried in the output tuser.
    localparam logic [StatusW-1:0] STAT_INSERT_DONE  = 2'd0;
    localparam logic [StatusW-1:0] STAT_REMOVE_DONE  = 2'd1;
    localparam logic [StatusW-1:0] STAT_REMOVE_EMPTY = 2'd2;

    typedef struct packed {
        logic [HeightW-1:0] height;
        logic [TagW-1:0]    tag;
    } t_entry;

endpackage
`default_nettype wire

// File: rtl/evicting_fifo_running_average_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drop-oldest FIFO with running mean height
// Circular store of tagged heights in a synchronous memory; an insert on a
// full store evicts the oldest entry and answers with the rounded mean.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake               Payload
// s        in   i_s_tvalid/o_s_tready   tuser: req_type; tdata: tag, height
// m        out  o_m_tvalid/i_m_tready   tuser: status; tdata: mean, tag, height
//
// One item is worked on at a time. A remove passes the read, evaluate and
// done states and loads its result in done; an insert also runs the
// bit-serial mean divider (one quotient bit per cycle) after evaluate. The
// next item can be accepted in the cycle after the load. The memory read of
// the head entry is registered. Reset is synchronous and active low and
// empties the queue. A finished result waits in the output register while the
// next item is accepted; a stalled output holds the block in its final step.
// ----------------------------------------------------------------------------
module evicting_fifo_running_average_top
    import efra_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [23:0] i_s_tdata,   // [15:0] element_tag, [23:16] element_height
    input  wire  [0:0]  i_s_tuser,   // [0] req_type
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] mean_height, [23:8] removed_tag,
                                     // [31:24] removed_height
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    localparam int W_IDX  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int W_CNT  = $clog2(QUEUE_DEPTH + 1);
    localparam int W_SUM  = HeightW + W_CNT;
    localparam int W_DIV  = W_SUM + 2;
    localparam int W_SLOT = W_IDX + 2;
    localparam int QBITS  = HeightW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    t_entry r_mem [0:QUEUE_DEPTH-1];
    t_entry r_rd;

    logic [2:0]         r_state, n_state;
    logic               r_req, n_req;
    logic [TagW-1:0]    r_tag_in, n_tag_in;
    logic [HeightW-1:0] r_hgt_in, n_hgt_in;
    logic [W_IDX-1:0]   r_head, n_head;
    logic [W_CNT-1:0]   r_count, n_count;
    logic [W_SUM-1:0]   r_sum, n_sum;
    logic [W_DIV-1:0]   r_rem, n_rem;
    logic [W_DIV-1:0]   r_trial, n_trial;
    logic [QBITS-1:0]   r_quot, n_quot;
    logic [2:0]         r_step, n_step;
    logic [StatusW-1:0] r_status, n_status;
    logic [TagW-1:0]    r_rm_tag, n_rm_tag;
    logic [HeightW-1:0] r_rm_hgt, n_rm_hgt;
    logic               r_out_valid, n_out_valid;
    logic [31:0]        r_out_data, n_out_data;
    logic [1:0]         r_out_user, n_out_user;

    logic               mem_we;
    logic [W_IDX-1:0]   mem_waddr;
    t_entry             mem_wdata;

    logic               w_full;
    logic [W_IDX-1:0]   w_head_inc;
    logic [W_SLOT-1:0]  w_slot_raw;
    logic [W_IDX-1:0]   w_tail;
    logic [W_CNT-1:0]   w_ins_count;
    logic [W_SUM-1:0]   w_ins_sum;
    logic [W_DIV-1:0]   w_trial_sub;
    logic               w_out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    assign w_full     = (r_count == W_CNT'(QUEUE_DEPTH));
    assign w_head_inc = (r_head == W_IDX'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_slot_raw = W_SLOT'(r_head) + W_SLOT'(r_count);
    // On a full store the new entry lands in the evicted head slot.
    assign w_tail     = w_full ? r_head :
                        (w_slot_raw >= W_SLOT'(QUEUE_DEPTH)) ?
                        W_IDX'(w_slot_raw - W_SLOT'(QUEUE_DEPTH)) : W_IDX'(w_slot_raw);
    assign w_ins_count = w_full ? r_count : r_count + 1'b1;
    assign w_ins_sum   = r_sum - (w_full ? W_SUM'(r_rd.height) : '0) + W_SUM'(r_hgt_in);
    assign w_trial_sub = r_rem - r_trial;
    assign w_out_free  = !r_out_valid || i_m_tready;

    // The head is read only after the previous item's write has landed, so
    // no forwarding is needed around the memory.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[r_head];
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_tag_in    = r_tag_in;
        n_hgt_in    = r_hgt_in;
        n_head      = r_head;
        n_count     = r_count;
        n_sum       = r_sum;
        n_rem       = r_rem;
        n_trial     = r_trial;
        n_quot      = r_quot;
        n_step      = r_step;
        n_status    = r_status;
        n_rm_tag    = r_rm_tag;
        n_rm_hgt    = r_rm_hgt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        mem_we      = 1'b0;
        mem_waddr   = w_tail;
        mem_wdata   = '{height: r_hgt_in, tag: r_tag_in};

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_req    = i_s_tuser[0];
                    n_tag_in = i_s_tdata[TagW-1:0];
                    n_hgt_in = i_s_tdata[TagW+HeightW-1:TagW];
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_quot   = '0;
                n_rm_tag = '0;
                n_rm_hgt = '0;
                if (r_req == REQ_REMOVE) begin
                    if (r_count == '0) begin
                        n_status = STAT_REMOVE_EMPTY;
                    end else begin
                        n_status = STAT_REMOVE_DONE;
                        n_rm_tag = r_rd.tag;
                        n_rm_hgt = r_rd.height;
                        n_sum    = r_sum - W_SUM'(r_rd.height);
                        n_head   = w_head_inc;
                        n_count  = r_count - 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    mem_we   = 1'b1;
                    n_status = STAT_INSERT_DONE;
                    n_count  = w_ins_count;
                    n_sum    = w_ins_sum;
                    if (w_full) begin
                        n_head = w_head_inc;
                    end
                    // Mean rounded half up: (2*sum + count) / (2*count).
                    n_rem   = (W_DIV'(w_ins_sum) << 1) + W_DIV'(w_ins_count);
                    n_trial = W_DIV'(w_ins_count) << (QBITS);
                    n_step  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_rem >= r_trial) begin
                    n_rem  = w_trial_sub;
                    n_quot = {r_quot[QBITS-2:0], 1'b1};
                end else begin
                    n_quot = {r_quot[QBITS-2:0], 1'b0};
                end
                n_trial = r_trial >> 1;
                n_step  = r_step + 1'b1;
                if (r_step == 3'(QBITS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_rm_hgt, r_rm_tag, r_quot};
                    n_out_user  = r_status;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_tag_in   <= n_tag_in;
        r_hgt_in   <= n_hgt_in;
        r_rem      <= n_rem;
        r_trial    <= n_trial;
        r_quot     <= n_quot;
        r_step     <= n_step;
        r_status   <= n_status;
        r_rm_tag   <= n_rm_tag;
        r_rm_hgt   <= n_rm_hgt;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

endmodule
`default_nettype wire
